>>> rtl/array_doubly_linked_list_assert.svh
// assertion macros for the linked list block
`ifndef ARRAY_DOUBLY_LINKED_LIST_ASSERT_SVH
`define ARRAY_DOUBLY_LINKED_LIST_ASSERT_SVH

`ifndef SYNTHESIS

`define ADLL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("adll assertion failed");

`define ADLL_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("adll assertion failed");

`else

`define ADLL_ASSERT_IMP(name, ante, cons)

`define ADLL_ASSERT_NXT(name, ante, cons)

`endif

`endif

>>> rtl/adll_pkg.sv
// shared types and codes for the linked list block
`timescale 1ns / 1ps

package adll_pkg;

    localparam int OP_W     = 3;
    localparam int NUM_W    = 11;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam int DEFAULT_CAPACITY = 1024;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_RIGHT  = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_LEFT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;
    localparam logic [OP_W-1:0] OP_READ       = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [NUM_W-1:0]         position;
        logic signed [DATA_W-1:0] data_value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [NUM_W-1:0]         assigned_number;
        logic signed [DATA_W-1:0] read_value;
        logic [NUM_W-1:0]         next_number;
    } rsp_t;

endpackage

>>> rtl/adll_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module adll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1026
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/adll_ctrl.sv
// operation sequencer: reads, patches and writes back the node records
`timescale 1ns / 1ps

module adll_ctrl #(
    parameter int CAPACITY = adll_pkg::DEFAULT_CAPACITY,
    parameter int SW       = $clog2(CAPACITY + 2)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  adll_pkg::cmd_t        s_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output adll_pkg::rsp_t        rsp,
    output logic                  link_we,
    output logic [SW-1:0]         link_waddr,
    output logic [2*SW:0]         link_wdata,
    output logic [SW-1:0]         link_raddr,
    input  logic [2*SW:0]         link_rdata,
    output logic                  val_we,
    output logic [SW-1:0]         val_waddr,
    output logic [adll_pkg::DATA_W-1:0] val_wdata,
    output logic [SW-1:0]         val_raddr,
    input  logic [adll_pkg::DATA_W-1:0] val_rdata
);

    import adll_pkg::*;

    localparam int SLOTS = CAPACITY + 2;
    localparam int FW    = $clog2(SLOTS + 1);
    localparam int PW    = (FW > NUM_W + 1) ? FW : NUM_W + 1;
    localparam logic [SW-1:0] HEAD_SLOT = '0;
    localparam logic [SW-1:0] TAIL_SLOT = SW'(1);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CHECK   = 8'b0000_0010,
        S_INS_NEW = 8'b0000_0100,
        S_INS_NB  = 8'b0000_1000,
        S_INS_AT  = 8'b0001_0000,
        S_DEL_LF  = 8'b0010_0000,
        S_DEL_RT  = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [FW-1:0]       free_reg, free_next;
    logic [SW-1:0]       head_right_reg, head_right_next;
    logic [SW-1:0]       tail_left_reg, tail_left_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic                pos_ok_reg, pos_ok_next;
    logic [SW-1:0]       k_reg, k_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [SW-1:0]       at_reg, at_next;
    logic [SW-1:0]       nb_reg, nb_next;
    rsp_t                rsp_reg, rsp_next;

    logic                rec_present;
    logic [SW-1:0]       rec_left;
    logic [SW-1:0]       rec_right;
    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       k_full;
    logic                in_pos_ok;
    logic                full;
    logic [SW-1:0]       new_slot;

    // slot number to insertion number, sentinels read as zero
    function automatic logic [NUM_W-1:0] slot_num(input logic [SW-1:0] s);
        logic [PW-1:0] t;
        t = PW'(s) - PW'(1);
        return (s <= TAIL_SLOT) ? '0 : t[NUM_W-1:0];
    endfunction

    assign rec_present = link_rdata[2*SW];
    assign rec_left    = link_rdata[2*SW-1:SW];
    assign rec_right   = link_rdata[SW-1:0];

    assign pos_ext   = PW'(s_data.position);
    assign k_full    = pos_ext + PW'(1);
    // slots at or beyond the fill count were never written
    assign in_pos_ok = (pos_ext != '0) && (k_full < PW'(free_reg));
    assign full      = (free_reg == FW'(SLOTS));
    assign new_slot  = free_reg[SW-1:0];

    assign s_ready   = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);
    assign rsp       = rsp_reg;

    always_comb begin
        state_next      = state_reg;
        free_next       = free_reg;
        head_right_next = head_right_reg;
        tail_left_next  = tail_left_reg;
        op_next         = op_reg;
        pos_ok_next     = pos_ok_reg;
        k_next          = k_reg;
        val_next        = val_reg;
        at_next         = at_reg;
        nb_next         = nb_reg;
        rsp_next        = rsp_reg;
        link_we         = 1'b0;
        link_waddr      = k_reg;
        link_wdata      = link_rdata;
        link_raddr      = k_reg;
        val_we          = 1'b0;
        val_waddr       = new_slot;
        val_wdata       = val_reg;
        val_raddr       = k_reg;

        unique case (state_reg)
            S_IDLE: begin
                link_raddr = k_full[SW-1:0];
                val_raddr  = k_full[SW-1:0];
                if (s_valid) begin
                    op_next     = s_data.operation;
                    pos_ok_next = in_pos_ok;
                    k_next      = k_full[SW-1:0];
                    val_next    = s_data.data_value;
                    rsp_next    = '0;
                    unique case (s_data.operation)
                        OP_PUSH_FRONT: begin
                            at_next = HEAD_SLOT;
                            nb_next = head_right_reg;
                            if (full) begin
                                rsp_next.status = STATUS_FULL;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_INS_NEW;
                            end
                        end
                        OP_PUSH_BACK: begin
                            at_next = tail_left_reg;
                            nb_next = TAIL_SLOT;
                            if (full) begin
                                rsp_next.status = STATUS_FULL;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_INS_NEW;
                            end
                        end
                        OP_INS_RIGHT, OP_INS_LEFT, OP_DELETE: begin
                            state_next = S_CHECK;
                        end
                        OP_READ: begin
                            if (s_data.position == '0) begin
                                rsp_next.next_number = slot_num(head_right_reg);
                                state_next           = S_RESP;
                            end else begin
                                state_next = S_CHECK;
                            end
                        end
                        default: begin
                            rsp_next.status = STATUS_BAD;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (!(pos_ok_reg && rec_present)) begin
                    rsp_next.status = STATUS_BAD;
                    state_next      = S_RESP;
                end else begin
                    unique case (op_reg)
                        OP_INS_RIGHT: begin
                            at_next = k_reg;
                            nb_next = rec_right;
                            if (full) begin
                                rsp_next.status = STATUS_FULL;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_INS_NEW;
                            end
                        end
                        OP_INS_LEFT: begin
                            at_next = rec_left;
                            nb_next = k_reg;
                            if (full) begin
                                rsp_next.status = STATUS_FULL;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_INS_NEW;
                            end
                        end
                        OP_DELETE: begin
                            link_we    = 1'b1;
                            link_waddr = k_reg;
                            link_wdata = {1'b0, rec_left, rec_right};
                            link_raddr = rec_left;
                            at_next    = rec_left;
                            nb_next    = rec_right;
                            state_next = S_DEL_LF;
                        end
                        OP_READ: begin
                            rsp_next.read_value  = val_rdata;
                            rsp_next.next_number = slot_num(rec_right);
                            state_next           = S_RESP;
                        end
                        default: begin
                            rsp_next.status = STATUS_BAD;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end
            S_INS_NEW: begin
                link_we    = 1'b1;
                link_waddr = new_slot;
                link_wdata = {1'b1, at_reg, nb_reg};
                val_we     = 1'b1;
                link_raddr = nb_reg;
                state_next = S_INS_NB;
            end
            S_INS_NB: begin
                if (nb_reg == TAIL_SLOT) begin
                    tail_left_next = new_slot;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = nb_reg;
                    link_wdata = {rec_present, new_slot, rec_right};
                end
                link_raddr = at_reg;
                state_next = S_INS_AT;
            end
            S_INS_AT: begin
                if (at_reg == HEAD_SLOT) begin
                    head_right_next = new_slot;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = at_reg;
                    link_wdata = {rec_present, rec_left, new_slot};
                end
                free_next                = free_reg + FW'(1);
                rsp_next.assigned_number = slot_num(new_slot);
                state_next               = S_RESP;
            end
            S_DEL_LF: begin
                if (at_reg == HEAD_SLOT) begin
                    head_right_next = nb_reg;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = at_reg;
                    link_wdata = {rec_present, rec_left, nb_reg};
                end
                link_raddr = nb_reg;
                state_next = S_DEL_RT;
            end
            S_DEL_RT: begin
                if (nb_reg == TAIL_SLOT) begin
                    tail_left_next = at_reg;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = nb_reg;
                    link_wdata = {rec_present, at_reg, rec_right};
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            free_reg       <= FW'(2);
            head_right_reg <= TAIL_SLOT;
            tail_left_reg  <= HEAD_SLOT;
        end else begin
            state_reg      <= state_next;
            free_reg       <= free_next;
            head_right_reg <= head_right_next;
            tail_left_reg  <= tail_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        pos_ok_reg <= pos_ok_next;
        k_reg      <= k_next;
        val_reg    <= val_next;
        at_reg     <= at_next;
        nb_reg     <= nb_next;
        rsp_reg    <= rsp_next;
    end

endmodule

>>> rtl/array_doubly_linked_list.sv
// Doubly linked list over node memories, one operation per input beat.
// Input channel s_valid/s_ready/s_data carries operation, position and value;
// the result channel m_valid/m_ready/m_data returns status, the new insertion
// number, a read value and the right neighbour's number, one beat per input.
// Slot 0 is the head sentinel, slot 1 the tail; insertion number k sits in slot k+1.
// From S_IDLE an unknown code or a read of the head goes straight to S_RESP;
// push front/back passes S_INS_NEW, S_INS_NB, S_INS_AT; insert left/right of
// k adds S_CHECK first; delete passes S_CHECK, S_DEL_LF, S_DEL_RT; a read of
// k passes S_CHECK. The next input is taken in the cycle after the result
// leaves the sequencer; the link memory's one read and one write port set
// these steps, as each insert or delete patches one record per cycle.
// Reset empties the list: the sentinel links live in flops and
// node presence is qualified by the fill count, so no memory clearing pass.
// A stalled receiver holds the result in the output register; the block
// keeps working on the next item and waits only when that result is ready.
`timescale 1ns / 1ps

`include "array_doubly_linked_list_assert.svh"

module array_doubly_linked_list #(
    parameter int CAPACITY = adll_pkg::DEFAULT_CAPACITY
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  adll_pkg::cmd_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output adll_pkg::rsp_t m_data
);

    import adll_pkg::*;

    localparam int SLOTS = CAPACITY + 2;
    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = 2 * SW + 1;

    logic              rsp_valid;
    logic              rsp_ready;
    rsp_t              rsp;
    logic              link_we;
    logic [SW-1:0]     link_waddr;
    logic [LW-1:0]     link_wdata;
    logic [SW-1:0]     link_raddr;
    logic [LW-1:0]     link_rdata;
    logic              val_we;
    logic [SW-1:0]     val_waddr;
    logic [DATA_W-1:0] val_wdata;
    logic [SW-1:0]     val_raddr;
    logic [DATA_W-1:0] val_rdata;
    logic              m_valid_reg;
    rsp_t              m_data_reg;
    logic              m_fields_zero;

    adll_ctrl #(
        .CAPACITY (CAPACITY),
        .SW       (SW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata),
        .val_we     (val_we),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .val_raddr  (val_raddr),
        .val_rdata  (val_rdata)
    );

    // present bit, left link, right link per slot
    adll_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    adll_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // output register parts the sequencer from the receiver
    assign rsp_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rsp_valid && rsp_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_valid && rsp_ready) begin
            m_data_reg <= rsp;
        end
    end

    assign m_fields_zero = (m_data.assigned_number == '0) && (m_data.read_value == '0)
                           && (m_data.next_number == '0);

    `ADLL_ASSERT_IMP(a_idle_no_rsp, s_ready, !rsp_valid)
    `ADLL_ASSERT_NXT(a_rsp_back_to_idle, rsp_valid && rsp_ready, s_ready)
    `ADLL_ASSERT_IMP(a_fail_fields_zero, m_valid && (m_data.status != STATUS_OK), m_fields_zero)

endmodule

>>> tb/testbench.sv
// self-checking testbench for the array doubly linked list block
`timescale 1ns / 1ps

module testbench;
    import adll_pkg::*;

    localparam int CAPACITY    = DEFAULT_CAPACITY;
    localparam int SLOTS       = CAPACITY + 2;
    localparam int HEAD_SLOT   = 0;
    localparam int TAIL_SLOT   = 1;
    localparam int PERIOD      = 10;
    localparam int ITEMS       = 1200;
    localparam int FULL_TARGET = 30;
    localparam int IDLE_PCT    = 37;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_FROM  = 600;
    localparam int QUIET_TO    = 800;
    localparam int DRAIN       = 20;
    localparam int MAX_REPORTS = 10;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        cmd_t cmd;
        bit   typed;
        rsp_t want;
    } script_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cmd_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    // shadow of the list
    logic signed [DATA_W-1:0] node_val  [0:SLOTS-1];
    logic [NUM_W-1:0]         right_lnk [0:SLOTS-1];
    logic [NUM_W-1:0]         left_lnk  [0:SLOTS-1];
    bit                       present   [0:SLOTS-1];
    int unsigned              free_slot;
    logic [NUM_W-1:0]         walk_next;
    int                       full_seen;

    rsp_t        awaited_results [$];
    script_row_t script [$];
    int          mismatches = 0;
    int          in_count   = 0;
    int          idle_cycles = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;
    wire         quiet = (in_count >= QUIET_FROM) && (in_count < QUIET_TO);

    array_doubly_linked_list #(
        .CAPACITY (CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    function automatic void clear_list();
        for (int i = 0; i < SLOTS; i++) begin
            present[i]   = 1'b0;
            right_lnk[i] = '0;
            left_lnk[i]  = '0;
            node_val[i]  = '0;
        end
        right_lnk[HEAD_SLOT] = NUM_W'(TAIL_SLOT);
        left_lnk[TAIL_SLOT]  = NUM_W'(HEAD_SLOT);
        free_slot = 2;
        walk_next = '0;
        full_seen = 0;
    endfunction

    // slot of a live insertion number, 0 if none
    function automatic logic [NUM_W-1:0] live_slot(logic [NUM_W-1:0] pos);
        int k;
        k = pos;
        if (k == 0 || k > CAPACITY) return '0;
        if (!present[k + 1]) return '0;
        return NUM_W'(k + 1);
    endfunction

    function automatic logic [NUM_W-1:0] slot_number(logic [NUM_W-1:0] s);
        return (s <= TAIL_SLOT) ? '0 : s - 1'b1;
    endfunction

    function automatic rsp_t apply_list_op(cmd_t c);
        rsp_t             r;
        logic [NUM_W-1:0] at, lf, rt, s, nb;
        bit               ins, full;
        r    = '0;
        at   = '0;
        ins  = 1'b0;
        full = (free_slot >= SLOTS);
        case (c.operation)
            OP_PUSH_FRONT: begin
                at  = NUM_W'(HEAD_SLOT);
                ins = 1'b1;
            end
            OP_PUSH_BACK: begin
                at  = left_lnk[TAIL_SLOT];
                ins = 1'b1;
            end
            OP_INS_RIGHT, OP_INS_LEFT: begin
                at = live_slot(c.position);
                if (at == 0) begin
                    r.status = STATUS_BAD;
                end else begin
                    if (c.operation == OP_INS_LEFT) at = left_lnk[at];
                    ins = 1'b1;
                end
            end
            OP_DELETE: begin
                at = live_slot(c.position);
                if (at == 0) begin
                    r.status = STATUS_BAD;
                end else begin
                    lf = left_lnk[at];
                    rt = right_lnk[at];
                    right_lnk[lf] = rt;
                    left_lnk[rt]  = lf;
                    present[at]   = 1'b0;
                end
            end
            OP_READ: begin
                if (c.position == 0) begin
                    r.next_number = slot_number(right_lnk[HEAD_SLOT]);
                end else begin
                    at = live_slot(c.position);
                    if (at == 0) begin
                        r.status = STATUS_BAD;
                    end else begin
                        r.read_value  = node_val[at];
                        r.next_number = slot_number(right_lnk[at]);
                    end
                end
                if (r.status == STATUS_OK) walk_next = r.next_number;
            end
            default: begin
                r.status = STATUS_BAD;
            end
        endcase
        if (ins) begin
            if (full) begin
                r.status  = STATUS_FULL;
                full_seen = full_seen + 1;
            end else begin
                s  = NUM_W'(free_slot);
                nb = right_lnk[at];
                node_val[s]  = c.data_value;
                left_lnk[s]  = at;
                right_lnk[s] = nb;
                left_lnk[nb] = s;
                right_lnk[at] = s;
                present[s]   = 1'b1;
                free_slot    = free_slot + 1;
                r.assigned_number = slot_number(s);
            end
        end
        return r;
    endfunction

    // mostly a live number; a dead one when few are left
    function automatic logic [NUM_W-1:0] pick_live();
        int unsigned made, k;
        made = free_slot - 2;
        k    = 1;
        if (made == 0) return '0;
        for (int tries = 0; tries < 16; tries++) begin
            k = $urandom_range(made, 1);
            if (present[k + 1]) break;
        end
        return NUM_W'(k);
    endfunction

    // insert heavy mix so the store fills within the item budget
    function automatic cmd_t random_cmd();
        cmd_t        c;
        int unsigned p, q;
        p = $urandom_range(99);
        q = $urandom_range(99);
        c.data_value = $urandom;
        c.position   = NUM_W'($urandom_range(2047));
        if (p < 25) begin
            c.operation = OP_PUSH_FRONT;
        end else if (p < 50) begin
            c.operation = OP_PUSH_BACK;
        end else if (p < 93) begin
            if (p < 70)      c.operation = OP_INS_RIGHT;
            else if (p < 88) c.operation = OP_INS_LEFT;
            else             c.operation = OP_DELETE;
            if (q < 88) c.position = pick_live();
        end else if (p < 99) begin
            c.operation = OP_READ;
            if (q < 70)      c.position = walk_next;
            else if (q < 90) c.position = pick_live();
        end else begin
            c.operation = (q < 50) ? OP_SPARE_6 : OP_SPARE_7;
        end
        return c;
    endfunction

    function automatic script_row_t step_row(logic [OP_W-1:0] op, int pos, int data, bit typed,
                                             logic [STATUS_W-1:0] st, int asg, int rv, int nx);
        script_row_t row;
        row.cmd.operation        = op;
        row.cmd.position         = NUM_W'(pos);
        row.cmd.data_value       = data;
        row.typed                = typed;
        row.want.status          = st;
        row.want.assigned_number = NUM_W'(asg);
        row.want.read_value      = rv;
        row.want.next_number     = NUM_W'(nx);
        return row;
    endfunction

    task automatic send_beat(cmd_t c, bit typed, rsp_t want);
        rsp_t got;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        got = apply_list_op(c);
        awaited_results.push_back(typed ? want : got);
    endtask

    initial begin : stimulus
        int n;
        clear_list();
        script.push_back(step_row(OP_READ,       0,    0,            1, STATUS_OK,  0, 0, 0));
        script.push_back(step_row(OP_DELETE,     1,    0,            1, STATUS_BAD, 0, 0, 0));
        script.push_back(step_row(OP_INS_RIGHT,  0,    0,            1, STATUS_BAD, 0, 0, 0));
        script.push_back(step_row(OP_INS_LEFT,   1,    0,            1, STATUS_BAD, 0, 0, 0));
        script.push_back(step_row(OP_SPARE_6,    5,    32'h0f0f0f0f, 1, STATUS_BAD, 0, 0, 0));
        script.push_back(step_row(OP_SPARE_7,    2047, 32'hf0f0f0f0, 1, STATUS_BAD, 0, 0, 0));
        script.push_back(step_row(OP_READ,       2047, 0,            1, STATUS_BAD, 0, 0, 0));
        script.push_back(step_row(OP_PUSH_FRONT, 0,    32'h7fffffff, 1, STATUS_OK,  1, 0, 0));
        script.push_back(step_row(OP_PUSH_BACK,  0,    32'h80000000, 1, STATUS_OK,  2, 0, 0));
        script.push_back(step_row(OP_READ,       1,    0,  1, STATUS_OK, 0, 32'h7fffffff, 2));
        script.push_back(step_row(OP_READ,       2,    0,  1, STATUS_OK, 0, 32'h80000000, 0));
        script.push_back(step_row(OP_INS_RIGHT,  1,    -1,           1, STATUS_OK,  3, 0, 0));
        script.push_back(step_row(OP_INS_LEFT,   1,    0,            1, STATUS_OK,  4, 0, 0));
        script.push_back(step_row(OP_READ,       0,    0,            1, STATUS_OK,  0, 0, 4));
        script.push_back(step_row(OP_DELETE,     3,    0,            1, STATUS_OK,  0, 0, 0));
        // deleted node: every access is refused
        script.push_back(step_row(OP_DELETE,     3,    0,            1, STATUS_BAD, 0, 0, 0));
        script.push_back(step_row(OP_INS_RIGHT,  3,    0,            1, STATUS_BAD, 0, 0, 0));
        script.push_back(step_row(OP_READ,       4,    0,            1, STATUS_OK,  0, 0, 1));
        script.push_back(step_row(OP_READ,       1,    0,  1, STATUS_OK, 0, 32'h7fffffff, 2));
        script.push_back(step_row(OP_INS_RIGHT,  1025, 0,            1, STATUS_BAD, 0, 0, 0));
        script.push_back(step_row(OP_DELETE,     2047, 0,            1, STATUS_BAD, 0, 0, 0));
        script.push_back(step_row(OP_INS_LEFT,   2,    32'h12345678, 0, STATUS_OK,  0, 0, 0));
        script.push_back(step_row(OP_DELETE,     4,    0,            0, STATUS_OK,  0, 0, 0));
        script.push_back(step_row(OP_READ,       0,    32'hffffffff, 0, STATUS_OK,  0, 0, 0));
        script.push_back(step_row(OP_PUSH_FRONT, 2047, 32'h55aa55aa, 0, STATUS_OK,  0, 0, 0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (script[i]) send_beat(script[i].cmd, script[i].typed, script[i].want);
        // keep going for ITEMS beats and until the store has refused FULL_TARGET inserts
        n = 0;
        while (n < ITEMS || full_seen < FULL_TARGET) begin
            send_beat(random_cmd(), 1'b0, '0);
            n++;
        end
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) in_count <= in_count + 1;
    end

    // result side: random back-pressure, one long hold-off to fill the block, always ready while quiet
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && in_count >= HOLD_AT) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin : result_check
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result beat: status %0d assigned %0d value %0d next %0d",
                             m_data.status, m_data.assigned_number, m_data.read_value,
                             m_data.next_number);
                mismatches <= mismatches + 1;
            end else begin
                want = awaited_results.pop_front();
                if (m_data.status !== want.status
                        || m_data.assigned_number !== want.assigned_number
                        || m_data.read_value !== want.read_value
                        || m_data.next_number !== want.next_number) begin
                    if (mismatches < MAX_REPORTS)
                        $display({"mismatch: status %0d/%0d assigned %0d/%0d value %0d/%0d ",
                                  "next %0d/%0d (expected/actual)"},
                                 want.status, m_data.status,
                                 want.assigned_number, m_data.assigned_number,
                                 want.read_value, m_data.read_value,
                                 want.next_number, m_data.next_number);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/adll_pkg.sv
rtl/adll_ram.sv
rtl/adll_ctrl.sv
rtl/array_doubly_linked_list.sv
tb/testbench.sv
